@@ hw/rtl/mwf_pkg.sv @@
package mwf_pkg;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	typedef logic [PIX_W-1:0] pix_t;

	localparam pix_t PIX_MAX = 8'hFF;

	typedef enum logic [1:0] {
		MODE_BIN_ERODE   = 2'd0,
		MODE_BIN_DILATE  = 2'd1,
		MODE_GREY_ERODE  = 2'd2,
		MODE_GREY_DILATE = 2'd3
	} op_mode_t;

	// one line store entry: two rows back, one row back
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_word_t;

	// per-item control that follows the window through the filter stages
	typedef struct packed {
		logic res;
		logic last;
		logic top_out;
		logic bot_out;
		logic left_out;
		logic right_out;
	} win_ctl_t;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} result_t;

	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_AW    = 3;
	localparam int OFIFO_CW    = 4;

endpackage

@@ hw/rtl/mwf_line_mem.sv @@
module mwf_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output mwf_pkg::line_word_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  mwf_pkg::line_word_t wr_data
);
	import mwf_pkg::*;

	line_word_t mem [DEPTH];
	line_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-before-write on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/mwf_div.sv @@
module mwf_div #(
	parameter int NW = 22,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	import mwf_pkg::*;

	localparam int SW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		sh   = {rem_q, quo_q[NW-1]};
		ge   = sh >= {1'b0, div_q};
		diff = sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + SW'(1);
			if (step_q == SW'(NW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
		end
	end

	assign busy      = run_q || done_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

endmodule

@@ hw/rtl/mwf_filter.sv @@
module mwf_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  mwf_pkg::pix_t     top_pix,
	input  mwf_pkg::pix_t     mid_pix,
	input  mwf_pkg::pix_t     new_pix,
	input  mwf_pkg::win_ctl_t ctl,
	input  mwf_pkg::op_mode_t mode,
	output logic              push,
	output mwf_pkg::result_t  push_data,
	output logic [1:0]        pend
);
	import mwf_pkg::*;

	pix_t     window_q [9];
	logic     v_s2;
	win_ctl_t ctl_s2;

	pix_t       row_min [3];
	pix_t       row_max [3];
	logic [2:0] row_z;
	logic [2:0] row_nz;
	logic       cell_on;
	pix_t       pv;

	logic       v_s3;
	pix_t       rmin_s3 [3];
	pix_t       rmax_s3 [3];
	logic [2:0] rz_s3;
	logic [2:0] rnz_s3;
	pix_t       centre_s3;
	logic       border_s3;
	logic       last_s3;

	pix_t lo;
	pix_t hi;
	pix_t val;

	// window, column 2 newest; rows are two back, one back, current
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r*3]     <= window_q[r*3 + 1];
				window_q[r*3 + 1] <= window_q[r*3 + 2];
			end
			window_q[2] <= top_pix;
			window_q[5] <= mid_pix;
			window_q[8] <= new_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= shift && ctl.res;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl;
	end

	// per-row reduction over cells inside the image
	always_comb begin
		cell_on = 1'b0;
		pv      = '0;
		for (int r = 0; r < 3; r++) begin
			row_min[r] = PIX_MAX;
			row_max[r] = '0;
			row_z[r]   = 1'b0;
			row_nz[r]  = 1'b0;
			for (int c = 0; c < 3; c++) begin
				cell_on = !((r == 0) && ctl_s2.top_out) && !((r == 2) && ctl_s2.bot_out)
					&& !((c == 0) && ctl_s2.left_out) && !((c == 2) && ctl_s2.right_out);
				pv = window_q[r*3 + c];
				if (cell_on) begin
					if (pv < row_min[r]) row_min[r] = pv;
					if (pv > row_max[r]) row_max[r] = pv;
					if (!((r == 1) && (c == 1))) begin
						if (pv == '0) row_z[r] = 1'b1;
						else row_nz[r] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			rmin_s3[r] <= row_min[r];
			rmax_s3[r] <= row_max[r];
		end
		rz_s3     <= row_z;
		rnz_s3    <= row_nz;
		centre_s3 <= window_q[4];
		border_s3 <= ctl_s2.top_out || ctl_s2.bot_out || ctl_s2.left_out || ctl_s2.right_out;
		last_s3   <= ctl_s2.last;
	end

	always_comb begin
		lo = rmin_s3[0];
		hi = rmax_s3[0];
		for (int r = 1; r < 3; r++) begin
			if (rmin_s3[r] < lo) lo = rmin_s3[r];
			if (rmax_s3[r] > hi) hi = rmax_s3[r];
		end
		unique case (mode)
			MODE_BIN_ERODE: begin
				val = (!border_s3 && (centre_s3 != '0) && (|rz_s3)) ? '0 : centre_s3;
			end
			MODE_BIN_DILATE: begin
				val = (!border_s3 && (centre_s3 == '0) && (|rnz_s3)) ? PIX_MAX : centre_s3;
			end
			MODE_GREY_ERODE: begin
				val = lo;
			end
			MODE_GREY_DILATE: begin
				val = hi;
			end
			default: begin
				val = centre_s3;
			end
		endcase
	end

	assign push           = v_s3;
	assign push_data.pixel = val;
	assign push_data.last  = last_s3;
	assign pend           = {v_s3, v_s2};

endmodule

@@ hw/rtl/mwf_ofifo.sv @@
module mwf_ofifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  mwf_pkg::result_t                   push_data,
	input  logic                               pop,
	output logic                               valid,
	output mwf_pkg::result_t                   data,
	output logic [mwf_pkg::OFIFO_CW-1:0]       count
);
	import mwf_pkg::*;

	result_t              mem_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]  wr_ptr_q;
	logic [OFIFO_AW-1:0]  rd_ptr_q;
	logic [OFIFO_CW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + OFIFO_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + OFIFO_AW'(1);
			priority if (push && !pop) count_q <= count_q + OFIFO_CW'(1);
			else if (pop && !push) count_q <= count_q - OFIFO_CW'(1);
			else count_q <= count_q;
		end
	end

	assign valid = count_q != '0;
	assign data  = mem_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < OFIFO_CW'(OFIFO_DEPTH)))
		else $error("output queue overflow");

endmodule

@@ hw/rtl/morphology_3x3_window_filter_top.sv @@
// output: the result of the input transaction that completes a window passes the read stage,
// the window and row-reduction registers and the output queue before m_tvalid rises for it
// (that input transaction comes img_width + 1 items after the pixel itself)
// throughput: one item per cycle, one line store read and one write back per cycle; input
// stalls while the output queue can't hold every result in flight, and after a write to img_width
// until the divider has re-derived the output row/column
// reset: counters and window cleared, registers to 640 x 480 grey erosion; line stores not cleared
module morphology_3x3_window_filter_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mwf_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel_in
	input  logic                              s_tuser,   // [0] req_type
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mwf_pkg::PIX_W-1:0]         m_tdata,   // [7:0] pixel_out
	output logic                              m_tlast,   // frame_last
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mwf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mwf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mwf_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int XW  = CW + 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = HEIGHT_W + 1;
	localparam int OCW = $clog2(MAX_WIDTH * ((1 << HEIGHT_W) - 1) + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;
	localparam logic                 REQ_PIXEL      = 1'b0;

	// configuration registers
	logic [WIDTH_W-1:0]  img_width_q;
	logic [HEIGHT_W-1:0] img_height_q;
	op_mode_t            op_mode_q;
	logic                cfg_wr;
	logic                div_start_q;

	// frame position counters
	logic [CW-1:0]  in_column_q;
	logic [RW-1:0]  in_row_q;
	logic [OCW-1:0] out_count_q;
	logic [OCW-1:0] out_row_q;
	logic [CW-1:0]  out_col_q;

	// effective sizes
	logic [WW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	// accept-side decode
	logic         accept;
	logic         draining;
	logic         restart_req;
	logic         is_proc;
	logic         has_res;
	logic [XW-1:0] col_inc;
	logic         col_wrap;
	logic [XW-1:0] oc_inc;
	logic         oc_wrap;
	logic [OCW:0] orow_inc;
	logic [OCW:0] orow_next;
	logic         res_last;
	pix_t         new_pix;
	win_ctl_t     ctl_new;

	// read stage
	logic        v_s1;
	logic [CW-1:0] addr_s1;
	pix_t        pix_s1;
	win_ctl_t    ctl_s1;
	logic        fwd_s1;
	line_word_t  fwd_word_s1;
	line_word_t  rd_word;
	line_word_t  word_s1;
	line_word_t  wr_word;

	// divider
	logic           div_busy;
	logic           div_done;
	logic [OCW-1:0] div_quo;
	logic [WW-1:0]  div_rem;

	// output side
	logic                push;
	result_t             push_data;
	logic [1:0]          pend;
	logic                out_valid;
	result_t             out_data;
	logic [OFIFO_CW-1:0] fifo_cnt;
	logic [OFIFO_CW:0]   occ;

	// register write port, never back-pressured
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= 11'd640;
			img_height_q <= 12'd480;
			op_mode_q    <= MODE_GREY_ERODE;
			div_start_q  <= 1'b0;
		end else begin
			div_start_q <= cfg_wr && (cfg_index == CFG_IDX_WIDTH);
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_IDX_WIDTH:  img_width_q  <= cfg_data[WIDTH_W-1:0];
					CFG_IDX_HEIGHT: img_height_q <= cfg_data[HEIGHT_W-1:0];
					CFG_IDX_MODE:   op_mode_q    <= op_mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
		end
	end

	// zero size counts as one, width saturates at the line store depth
	always_comb begin
		priority if (img_width_q == '0) w_eff = WW'(1);
		else if (32'(img_width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(img_width_q);
		h_eff = (img_height_q == '0) ? HEIGHT_W'(1) : img_height_q;
	end

	// input transactions wait while a width change re-derives the output position
	// and while the output queue could not take every result still in flight
	assign occ      = (OFIFO_CW+1)'(fifo_cnt) + (OFIFO_CW+1)'(v_s1 && ctl_s1.res)
		+ (OFIFO_CW+1)'(pend[0]) + (OFIFO_CW+1)'(pend[1]);
	assign s_tready = !div_start_q && !div_busy && (occ < (OFIFO_CW+1)'(OFIFO_DEPTH));
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		col_inc  = XW'(in_column_q) + XW'(1);
		col_wrap = col_inc >= XW'(w_eff);
		// past the last input row only drain transactions are taken
		draining = in_row_q >= RW'(h_eff);
		// a drain beyond the frame or after every result restarts the frame
		restart_req = draining && ((in_row_q > (RW'(h_eff) + RW'(1)))
			|| (out_row_q >= OCW'(h_eff)));
		is_proc = draining ? !restart_req : (s_tuser == REQ_PIXEL);
		new_pix = draining ? '0 : s_tdata;
		// no result until one row plus one pixel has gone in
		has_res = !(((in_row_q == '0) && (XW'(in_column_q) <= XW'(w_eff)))
			|| ((in_row_q == RW'(1)) && (in_column_q == '0)));
		oc_inc    = XW'(out_col_q) + XW'(1);
		oc_wrap   = oc_inc >= XW'(w_eff);
		orow_inc  = (OCW+1)'(out_row_q) + (OCW+1)'(1);
		orow_next = oc_wrap ? orow_inc : (OCW+1)'(out_row_q);
		res_last  = orow_next >= (OCW+1)'(h_eff);
		// image-edge masks for the window centered on the next output pixel
		ctl_new.res       = has_res;
		ctl_new.last      = res_last;
		ctl_new.top_out   = out_row_q == '0;
		ctl_new.bot_out   = orow_inc >= (OCW+1)'(h_eff);
		ctl_new.left_out  = out_col_q == '0;
		ctl_new.right_out = oc_wrap;
	end

	// position counters; the last result of a frame puts everything back to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q    <= '0;
			out_count_q <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
		end else if (div_done) begin
			out_row_q <= div_quo;
			out_col_q <= CW'(div_rem);
		end else if (accept) begin
			priority if (!is_proc) begin
				if (draining) begin
					in_column_q <= '0;
					in_row_q    <= '0;
					out_count_q <= '0;
					out_row_q   <= '0;
					out_col_q   <= '0;
				end
			end else if (has_res && res_last) begin
				in_column_q <= '0;
				in_row_q    <= '0;
				out_count_q <= '0;
				out_row_q   <= '0;
				out_col_q   <= '0;
			end else begin
				in_column_q <= col_wrap ? '0 : CW'(col_inc);
				if (col_wrap) in_row_q <= in_row_q + RW'(1);
				if (has_res) begin
					out_count_q <= out_count_q + OCW'(1);
					out_col_q   <= oc_wrap ? '0 : CW'(oc_inc);
					out_row_q   <= OCW'(orow_next);
				end
			end
		end
	end

	// output row/column = out_count / width after a width change
	mwf_div #(
		.NW (OCW),
		.DW (WW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (out_count_q),
		.divisor   (w_eff),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// both line stores in one word: read at accept, write back in the read stage
	mwf_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept && is_proc),
		.rd_addr (in_column_q),
		.rd_data (rd_word),
		.wr_en   (v_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && is_proc;
		end
	end

	// with a one-pixel row the same entry is read while the previous write lands
	always_ff @(posedge clk) begin
		addr_s1     <= in_column_q;
		pix_s1      <= new_pix;
		ctl_s1      <= ctl_new;
		fwd_s1      <= v_s1 && (addr_s1 == in_column_q);
		fwd_word_s1 <= wr_word;
	end

	assign word_s1        = fwd_s1 ? fwd_word_s1 : rd_word;
	assign wr_word.upper  = word_s1.middle;
	assign wr_word.middle = pix_s1;

	mwf_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (v_s1),
		.top_pix   (word_s1.upper),
		.mid_pix   (word_s1.middle),
		.new_pix   (pix_s1),
		.ctl       (ctl_s1),
		.mode      (op_mode_q),
		.push      (push),
		.push_data (push_data),
		.pend      (pend)
	);

	mwf_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (m_tvalid && m_tready),
		.valid     (out_valid),
		.data      (out_data),
		.count     (fifo_cnt)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = out_data.pixel;
	assign m_tlast  = out_data.last;

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (OFIFO_CW+1)'(OFIFO_DEPTH))
		else $error("results in flight exceed output queue space");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_proc && has_res && res_last) |=>
		((in_column_q == '0) && (in_row_q == '0) && (out_count_q == '0)
		&& (out_row_q == '0) && (out_col_q == '0)))
		else $error("frame counters not cleared after last result");

	a_out_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!div_start_q && !div_busy) |-> (XW'(out_col_q) < XW'(w_eff)))
		else $error("output column beyond row width");

endmodule
